// ===== sv/tcpq_pkg.sv =====
// Shared types and codes for the three-class strict-priority order queue.
// Used by the per-class FIFO and by the top level; depends on nothing else.
package tcpq_pkg;

  localparam int ID_W        = 32;
  localparam int QTY_W       = 16;
  localparam int ENTRY_W     = ID_W + QTY_W;
  localparam int STATUS_W    = 2;
  localparam int CLS_W       = 2;
  localparam int NUM_CLASSES = 3;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  localparam logic [CLS_W-1:0] CLS_EXPRESS = 2'd0;
  localparam logic [CLS_W-1:0] CLS_VIP     = 2'd1;
  localparam logic [CLS_W-1:0] CLS_NORMAL  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_flags_t;

endpackage

// ===== sv/tcpq_fifo.sv =====
// One class queue: a FIFO of DEPTH order entries with registered read data.
// Depends on tcpq_pkg for the entry width and the control and flag structs.
module tcpq_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tcpq_pkg::fifo_ctrl_t         ctrl,
  input  logic [tcpq_pkg::ENTRY_W-1:0] wr_data,
  output tcpq_pkg::fifo_flags_t        flags,
  output logic [tcpq_pkg::ENTRY_W-1:0] rd_data
);
  import tcpq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   wptr_next;
  logic [PTR_W-1:0]   rptr_next;
  logic [CNT_W-1:0]   count_next;

  always_comb begin
    wptr_next  = wptr;
    rptr_next  = rptr;
    count_next = count;
    if (ctrl.push) begin
      wptr_next = (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
    end
    if (ctrl.pop) begin
      rptr_next = (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
    end
    case ({ctrl.push, ctrl.pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wptr] <= wr_data;
    end
    if (ctrl.pop) begin
      rd_data <= mem[rptr];
    end
  end

  assign flags.empty = (count == '0);
  assign flags.full  = (count == CNT_W'(DEPTH));

endmodule

// ===== sv/three_class_priority_queue_unit.sv =====
// Top level of the three-class strict-priority order queue.
// Depends on tcpq_pkg and instantiates one tcpq_fifo for each class.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_stall  req_type, priority_class, order_id, quantity
//   response  out        rsp_valid/rsp_stall  status, out_class, out_order_id, out_quantity
//
// One item is accepted per cycle while req_stall is low; its result passes the middle
// stage and then the output register before it can be taken.
// The decision is made from the class counts at acceptance, the FIFO read port
// registers the popped entry, and the output register holds the result.
// Reset empties all three classes; stored entries are not cleared.
// A stalled response backs up into the middle stage and then stalls the request side.
module three_class_priority_queue_unit #(
  parameter int CLASS_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          req_type,
  input  logic [tcpq_pkg::CLS_W-1:0]    priority_class,
  input  logic [tcpq_pkg::ID_W-1:0]     order_id,
  input  logic [tcpq_pkg::QTY_W-1:0]    quantity,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [tcpq_pkg::STATUS_W-1:0] status,
  output logic [tcpq_pkg::CLS_W-1:0]    out_class,
  output logic [tcpq_pkg::ID_W-1:0]     out_order_id,
  output logic [tcpq_pkg::QTY_W-1:0]    out_quantity
);
  import tcpq_pkg::*;

  fifo_ctrl_t         ctrl  [NUM_CLASSES];
  fifo_flags_t        flags [NUM_CLASSES];
  logic [ENTRY_W-1:0] rd_data [NUM_CLASSES];

  logic                accept;
  logic                out_load;
  logic [CLS_W-1:0]    enq_class;
  logic [STATUS_W-1:0] dec_status;
  logic [CLS_W-1:0]    dec_class;
  logic                s1_valid;
  logic [STATUS_W-1:0] s1_status;
  logic [CLS_W-1:0]    s1_class;
  logic [ENTRY_W-1:0]  s1_entry;

  assign out_load  = s1_valid && !(rsp_valid && rsp_stall);
  assign req_stall = s1_valid && !out_load;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    if (priority_class == CLS_EXPRESS) begin
      enq_class = CLS_EXPRESS;
    end else if (priority_class == CLS_VIP) begin
      enq_class = CLS_VIP;
    end else begin
      enq_class = CLS_NORMAL;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      ctrl[c] = '0;
    end
    dec_status = STATUS_EMPTY;
    dec_class  = CLS_EXPRESS;
    if (req_type == REQ_ENQUEUE) begin
      if (flags[enq_class].full) begin
        dec_status = STATUS_FULL;
      end else begin
        dec_status = STATUS_ENQUEUED;
        ctrl[enq_class].push = accept;
      end
    end else if (!flags[CLS_EXPRESS].empty) begin
      dec_status = STATUS_DEQUEUED;
      dec_class  = CLS_EXPRESS;
      ctrl[CLS_EXPRESS].pop = accept;
    end else if (!flags[CLS_VIP].empty) begin
      dec_status = STATUS_DEQUEUED;
      dec_class  = CLS_VIP;
      ctrl[CLS_VIP].pop = accept;
    end else if (!flags[CLS_NORMAL].empty) begin
      dec_status = STATUS_DEQUEUED;
      dec_class  = CLS_NORMAL;
      ctrl[CLS_NORMAL].pop = accept;
    end
  end

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_class
    tcpq_fifo #(
      .DEPTH (CLASS_DEPTH)
    ) u_fifo (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl[g]),
      .wr_data ({order_id, quantity}),
      .flags   (flags[g]),
      .rd_data (rd_data[g])
    );
  end

  always_comb begin
    case (s1_class)
      CLS_EXPRESS: s1_entry = rd_data[CLS_EXPRESS];
      CLS_VIP:     s1_entry = rd_data[CLS_VIP];
      CLS_NORMAL:  s1_entry = rd_data[CLS_NORMAL];
      default:     s1_entry = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= dec_status;
      s1_class  <= dec_class;
    end
    if (out_load) begin
      status <= s1_status;
      if (s1_status == STATUS_DEQUEUED) begin
        out_class    <= s1_class;
        out_order_id <= s1_entry[ENTRY_W-1:QTY_W];
        out_quantity <= s1_entry[QTY_W-1:0];
      end else begin
        out_class    <= CLS_EXPRESS;
        out_order_id <= '0;
        out_quantity <= '0;
      end
    end
  end

  // A class that reports full must never take another entry.
  assert property (@(posedge clk) disable iff (rst)
    !((ctrl[CLS_EXPRESS].push && flags[CLS_EXPRESS].full) ||
      (ctrl[CLS_VIP].push && flags[CLS_VIP].full) ||
      (ctrl[CLS_NORMAL].push && flags[CLS_NORMAL].full)))
    else $error("push into a full class");

  // A dequeue may only be served from a lower class when every higher class is empty.
  assert property (@(posedge clk) disable iff (rst)
    (!ctrl[CLS_VIP].pop || flags[CLS_EXPRESS].empty) &&
    (!ctrl[CLS_NORMAL].pop || (flags[CLS_EXPRESS].empty && flags[CLS_VIP].empty)))
    else $error("priority order violated on dequeue");

  // A dequeue accepted while all classes are empty reports the empty status.
  assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_DEQUEUE && flags[CLS_EXPRESS].empty &&
     flags[CLS_VIP].empty && flags[CLS_NORMAL].empty) |=> (s1_status == STATUS_EMPTY))
    else $error("dequeue on empty queue not reported as empty");

  // Results other than a dequeue carry zero in the order fields.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != STATUS_DEQUEUED) |->
      (out_class == CLS_EXPRESS && out_order_id == '0 && out_quantity == '0))
    else $error("non-dequeue result carries order data");

endmodule

// ===== tb/sv/tb_three_class_priority_queue_unit.sv =====
// Self-checking testbench for the three-class strict-priority order queue.
// Depends on tcpq_pkg and three_class_priority_queue_unit; it checks every response
// against a cycle-free queue predictor while both channels idle and stall at random.
module tb_three_class_priority_queue_unit;
  import tcpq_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam logic [CLS_W-1:0] CLS_OTHER = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CLS_W-1:0]    cls;
    logic [ID_W-1:0]     id;
    logic [QTY_W-1:0]    qty;
  } order_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               req_type = REQ_ENQUEUE;
  logic [CLS_W-1:0]   priority_class = CLS_EXPRESS;
  logic [ID_W-1:0]    order_id = '0;
  logic [QTY_W-1:0]   quantity = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [CLS_W-1:0]   out_class;
  logic [ID_W-1:0]    out_order_id;
  logic [QTY_W-1:0]   out_quantity;

  logic [ENTRY_W-1:0] class_slots [NUM_CLASSES][DEPTH];
  int                 head_idx [NUM_CLASSES];
  int                 tail_idx [NUM_CLASSES];
  int                 class_fill [NUM_CLASSES];

  order_result_t      pending_results [$];
  int                 mismatches = 0;
  int                 tx_max_gap = 15;
  int                 rx_max_gap = 15;
  int                 rx_hold_cycles = 0;
  int                 quiet_cycles = 0;

  three_class_priority_queue_unit #(
    .CLASS_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .priority_class(priority_class),
    .order_id(order_id),
    .quantity(quantity),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .out_class(out_class),
    .out_order_id(out_order_id),
    .out_quantity(out_quantity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Class index equals the class code; any code above VIP lands in the normal class.
  function automatic order_result_t queue_order(input logic req, input logic [CLS_W-1:0] cls,
                                                input logic [ID_W-1:0] id,
                                                input logic [QTY_W-1:0] qty);
    order_result_t r;
    int c;
    r = '0;
    if (req == REQ_ENQUEUE) begin
      c = (cls == CLS_EXPRESS) ? 0 : (cls == CLS_VIP) ? 1 : 2;
      if (class_fill[c] == DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        r.status = STATUS_ENQUEUED;
        class_slots[c][tail_idx[c]] = {id, qty};
        tail_idx[c] = (tail_idx[c] + 1) % DEPTH;
        class_fill[c]++;
      end
    end else begin
      c = 0;
      while (c < NUM_CLASSES && class_fill[c] == 0) c++;
      if (c == NUM_CLASSES) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.status = STATUS_DEQUEUED;
        r.cls = CLS_W'(c);
        {r.id, r.qty} = class_slots[c][head_idx[c]];
        head_idx[c] = (head_idx[c] + 1) % DEPTH;
        class_fill[c]--;
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic req, input logic [CLS_W-1:0] cls,
                              input logic [ID_W-1:0] id, input logic [QTY_W-1:0] qty);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req_type <= req;
    priority_class <= cls;
    order_id <= id;
    quantity <= qty;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(queue_order(req, cls, id, qty));
  endtask

  task automatic send_dequeue();
    send_request(REQ_DEQUEUE, CLS_W'($urandom_range(0, 3)), ID_W'($urandom),
                 QTY_W'($urandom_range(0, 65535)));
  endtask

  task automatic send_random(input int enqueue_pct);
    if ($urandom_range(0, 99) < enqueue_pct) begin
      send_request(REQ_ENQUEUE, CLS_W'($urandom_range(0, 3)), ID_W'($urandom),
                   QTY_W'($urandom_range(0, 65535)));
    end else begin
      send_dequeue();
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(REQ_DEQUEUE, CLS_OTHER, '1, '1);
    send_request(REQ_ENQUEUE, CLS_NORMAL, '0, '0);
    send_request(REQ_ENQUEUE, CLS_OTHER, '1, '1);
    send_request(REQ_ENQUEUE, CLS_VIP, 32'h8000_0001, 16'h8001);
    send_request(REQ_ENQUEUE, CLS_EXPRESS, '1, '0);
    send_request(REQ_ENQUEUE, CLS_EXPRESS, '0, '1);
    send_dequeue();
    send_request(REQ_ENQUEUE, CLS_VIP, 32'h7FFF_FFFE, 16'h7FFE);
    repeat (6) send_dequeue();
    send_request(REQ_ENQUEUE, CLS_NORMAL, 32'h5555_AAAA, 16'hA5A5);
    send_request(REQ_ENQUEUE, CLS_EXPRESS, 32'hAAAA_5555, 16'h5A5A);
    send_request(REQ_ENQUEUE, CLS_VIP, 32'h0F0F_F0F0, 16'hF00F);
    repeat (4) send_dequeue();
    wait_for_results();
  endtask

  task automatic test_class_full_and_wrap();
    logic [CLS_W-1:0] codes [NUM_CLASSES];
    int round;
    int c;
    for (round = 0; round < 2; round++) begin
      codes = '{CLS_EXPRESS, CLS_VIP, (round == 0) ? CLS_NORMAL : CLS_OTHER};
      for (c = 0; c < NUM_CLASSES; c++) begin
        repeat (DEPTH + 1) begin
          send_request(REQ_ENQUEUE, codes[c], ID_W'($urandom),
                       QTY_W'($urandom_range(0, 65535)));
        end
      end
      repeat (NUM_CLASSES * DEPTH + 2) send_dequeue();
    end
    wait_for_results();
  endtask

  task automatic test_random_mix();
    int tx_gaps [5] = '{15, 0, 15, 0, 7};
    int rx_gaps [5] = '{15, 0, 0, 15, 3};
    int enq_pct [5] = '{70, 50, 40, 60, 50};
    int p;
    for (p = 0; p < 5; p++) begin
      tx_max_gap = tx_gaps[p];
      rx_max_gap = rx_gaps[p];
      repeat (150) send_random(enq_pct[p]);
    end
    tx_max_gap = 15;
    rx_max_gap = 15;
    wait_for_results();
  endtask

  task automatic test_response_backpressure();
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold_cycles = 80;
    repeat (40) send_random(60);
    wait_for_results();
    tx_max_gap = 15;
    rx_max_gap = 15;
  endtask

  task automatic test_sender_pause();
    repeat (3) begin
      repeat (20) send_random(55);
      wait_for_results();
    end
  endtask

  initial begin : receiver
    int n;
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = $urandom_range(0, rx_max_gap);
      end
      @(negedge clk);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!(rsp_valid && !rsp_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    order_result_t want;
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $error("response with no request pending: status %0d", status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (out_class !== want.cls) begin
          $error("out_class: expected %0d, got %0d", want.cls, out_class);
          mismatches++;
        end
        if (out_order_id !== want.id) begin
          $error("out_order_id: expected %h, got %h", want.id, out_order_id);
          mismatches++;
        end
        if (out_quantity !== want.qty) begin
          $error("out_quantity: expected %h, got %h", want.qty, out_quantity);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_idx[c] = 0;
      tail_idx[c] = 0;
      class_fill[c] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_class_full_and_wrap();
    test_random_mix();
    test_response_backpressure();
    test_sender_pause();
    wait_for_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
